// File: design/sfe_pkg.sv
package sfe_pkg;

    localparam int LINE_DEPTH  = 65536;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int NUM_CH      = 2;
    localparam int SAMPLE_W    = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 17;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LINE_AW-1:0] line_addr_t;

    typedef struct packed {
        sample_t in_left;
        sample_t in_right;
    } in_word_t;

    typedef struct packed {
        sample_t out_left;
        sample_t out_right;
    } out_word_t;

    typedef struct packed {
        logic [16:0] mix_gain;
        logic [15:0] target_delay;
        logic [15:0] feedback_gain;
        logic [16:0] glide_coeff;
    } cfg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIX_GAIN      = 8'd0,
        REG_TARGET_DELAY  = 8'd1,
        REG_FEEDBACK_GAIN = 8'd2,
        REG_GLIDE_COEFF   = 8'd3
    } reg_idx_t;

    localparam cfg_t CFG_RESET = '{
        mix_gain:      17'd32768,
        target_delay:  16'd24000,
        feedback_gain: 16'd39322,
        glide_coeff:   17'd164
    };

    // One frame handed from the front to the back.
    typedef struct packed {
        sample_t [NUM_CH-1:0] smp;
        line_addr_t           rd_idx;
        line_addr_t           wr_idx;
        logic                 tap_valid;
    } q_entry_t;

    function automatic sample_t sat24(input logic signed [27:0] v);
        sample_t r;
        if (v > 28'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -28'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/sfe_ram.sv
module sfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sfe_queue.sv
module sfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfe_pkg::q_entry_t din,
    output logic              full,
    input  logic              pop,
    output sfe_pkg::q_entry_t dout,
    output logic              empty
);
    import sfe_pkg::*;

    q_entry_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wptr_reg;
    logic [QUEUE_AW-1:0]     rptr_reg;
    logic [QUEUE_AW:0]       count_reg;
    logic [QUEUE_AW:0]       count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

// File: design/sfe_front.sv
module sfe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sfe_pkg::in_word_t in_word,
    input  logic [15:0]       target_delay,
    input  logic [16:0]       glide_coeff,
    input  logic              q_full,
    output logic              q_push,
    output sfe_pkg::q_entry_t q_entry
);
    import sfe_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_PUSH} fstate_t;

    fstate_t                 state_reg;
    sample_t [NUM_CH-1:0]    smp_reg;
    logic [31:0]             smoothed_reg;
    logic signed [50:0]      prod_reg;
    line_addr_t              wr_ptr_reg;
    logic [LINE_AW:0]        fill_reg;

    logic signed [32:0]      diff;
    logic signed [50:0]      prod_next;
    logic signed [34:0]      step;
    logic signed [35:0]      nd;
    logic [31:0]             smoothed_next;
    line_addr_t              dly;
    line_addr_t              rd_idx;
    logic                    tap_valid;

    always_comb
    begin
        diff      = $signed({1'b0, target_delay, 16'b0}) - $signed({1'b0, smoothed_reg});
        prod_next = $signed({1'b0, glide_coeff}) * diff;
        // Arithmetic shift gives the floor of the Q16 product.
        step      = prod_reg[50:16];
        nd        = $signed({4'b0, smoothed_reg}) + $signed({step[34], step});
        if (nd[35])
        begin
            smoothed_next = '0;
        end
        else if (nd[34:32] != 3'b0)
        begin
            smoothed_next = 32'hFFFF_FFFF;
        end
        else
        begin
            smoothed_next = nd[31:0];
        end

        dly    = LINE_AW'(smoothed_reg[31:16]);
        rd_idx = wr_ptr_reg - line_addr_t'(1) - dly;
        // Lines fill in address order from reset, so an entry below the fill
        // count has been written and anything above it still reads as silence.
        tap_valid = fill_reg[LINE_AW] || ({1'b0, rd_idx} < fill_reg);
    end

    assign in_stall  = (state_reg != F_IDLE);
    assign q_push    = (state_reg == F_PUSH) && !q_full;
    assign q_entry.smp       = smp_reg;
    assign q_entry.rd_idx    = rd_idx;
    assign q_entry.wr_idx    = wr_ptr_reg;
    assign q_entry.tap_valid = tap_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            smp_reg      <= '0;
            smoothed_reg <= '0;
            prod_reg     <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        smp_reg[0] <= in_word.in_left;
                        smp_reg[1] <= in_word.in_right;
                        state_reg  <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= F_ADD;
                end
                F_ADD:
                begin
                    smoothed_reg <= smoothed_next;
                    state_reg    <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        wr_ptr_reg <= wr_ptr_reg + 1'b1;
                        if (!fill_reg[LINE_AW])
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/sfe_back.sv
module sfe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  sfe_pkg::q_entry_t  q_head,
    output logic               q_pop,
    input  logic [16:0]        mix_gain,
    input  logic [15:0]        feedback_gain,
    output logic               out_valid,
    input  logic               out_stall,
    output sfe_pkg::out_word_t out_word
);
    import sfe_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_READ, B_FB, B_Y, B_MIX, B_RES} bstate_t;

    bstate_t                  state_reg;
    q_entry_t                 ent_reg;
    logic signed [40:0]       fbp_reg  [NUM_CH];
    sample_t                  y_reg    [NUM_CH];
    logic signed [42:0]       mixp_reg [NUM_CH];
    logic                     out_valid_reg;
    out_word_t                out_reg;

    logic [SAMPLE_W-1:0]      tap_raw   [NUM_CH];
    sample_t                  tap       [NUM_CH];
    logic signed [40:0]       fbp_next  [NUM_CH];
    logic signed [25:0]       fb_sum    [NUM_CH];
    sample_t                  y_next    [NUM_CH];
    logic signed [24:0]       wet_diff  [NUM_CH];
    logic signed [42:0]       mixp_next [NUM_CH];
    logic signed [27:0]       mix_sum   [NUM_CH];
    sample_t                  res       [NUM_CH];
    logic                     rd_en;
    logic                     wr_en;
    logic                     load_out;

    assign rd_en    = (state_reg == B_READ);
    assign wr_en    = (state_reg == B_Y);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign load_out = (state_reg == B_RES) && (!out_valid_reg || !out_stall);

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_line
        sfe_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (LINE_DEPTH)
        ) u_line (
            .clk   (clk),
            .we    (wr_en),
            .waddr (ent_reg.wr_idx),
            .wdata (y_next[ch]),
            .re    (rd_en),
            .raddr (ent_reg.rd_idx),
            .rdata (tap_raw[ch])
        );
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            tap[ch]      = ent_reg.tap_valid ? $signed(tap_raw[ch]) : '0;
            fbp_next[ch] = $signed({1'b0, feedback_gain}) * tap[ch];
            fb_sum[ch]   = $signed({{2{ent_reg.smp[ch][SAMPLE_W-1]}}, ent_reg.smp[ch]})
                         + $signed({fbp_reg[ch][40], fbp_reg[ch][40:16]});
            y_next[ch]   = sat24($signed({{2{fb_sum[ch][25]}}, fb_sum[ch]}));
            wet_diff[ch] = $signed({y_reg[ch][SAMPLE_W-1], y_reg[ch]})
                         - $signed({ent_reg.smp[ch][SAMPLE_W-1], ent_reg.smp[ch]});
            mixp_next[ch] = $signed({1'b0, mix_gain}) * wet_diff[ch];
            mix_sum[ch]  = $signed({{4{ent_reg.smp[ch][SAMPLE_W-1]}}, ent_reg.smp[ch]})
                         + $signed({mixp_reg[ch][42], mixp_reg[ch][42:16]});
            res[ch]      = sat24(mix_sum[ch]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ent_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                fbp_reg[ch]  <= '0;
                y_reg[ch]    <= '0;
                mixp_reg[ch] <= '0;
            end
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg    <= 1'b1;
                out_reg.out_left  <= res[0];
                out_reg.out_right <= res[1];
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        ent_reg   <= q_head;
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_FB;
                end
                B_FB:
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        fbp_reg[ch] <= fbp_next[ch];
                    end
                    state_reg <= B_Y;
                end
                B_Y:
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        y_reg[ch] <= y_next[ch];
                    end
                    state_reg <= B_MIX;
                end
                B_MIX:
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        mixp_reg[ch] <= mixp_next[ch];
                    end
                    state_reg <= B_RES;
                end
                B_RES:
                begin
                    if (load_out)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/smoothed_feedback_echo_top.sv
// Stereo feedback echo with a gliding delay. Each accepted input word is one
// stereo frame and yields exactly one output word. The front section takes a
// new frame only once it has updated the smoothed delay and pushed the last
// frame; the back section reads the delay lines, applies feedback and mix,
// and writes the lines back before it takes the next frame, so the sustained
// rate is set by the back sequencer and its line memories, which have one
// read and one write port each. A two-word queue sits between the sections
// and an output register holds a finished word while the next frame is
// worked on. The lines read as silence after reset without any clearing
// pass, so frames are accepted from the first cycle. Configuration writes
// are always ready and must only be issued while the block is idle.
module smoothed_feedback_echo_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sfe_pkg::in_word_t                 in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sfe_pkg::out_word_t                out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfe_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    q_entry_t q_in;
    q_entry_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIX_GAIN:      cfg_reg.mix_gain      <= cfg_data[16:0];
                REG_TARGET_DELAY:  cfg_reg.target_delay  <= cfg_data[15:0];
                REG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= cfg_data[15:0];
                REG_GLIDE_COEFF:   cfg_reg.glide_coeff   <= cfg_data[16:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .target_delay (cfg_reg.target_delay),
        .glide_coeff  (cfg_reg.glide_coeff),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    sfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    sfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .mix_gain      (cfg_reg.mix_gain),
        .feedback_gain (cfg_reg.feedback_gain),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word)
    );

endmodule

// File: tb/sv/smoothed_feedback_echo_checker.sv
`timescale 1ns / 100ps

module smoothed_feedback_echo_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  sfe_pkg::in_word_t              in_word,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  sfe_pkg::out_word_t             out_word,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             frames_out
);
    import sfe_pkg::*;

    localparam longint SAMPLE_TOP    = 8388607;
    localparam longint SAMPLE_BOTTOM = -8388608;
    localparam longint GLIDE_TOP     = 64'h0000_0000_FFFF_FFFF;

    cfg_t        regs;
    logic [15:0] wr_ptr;
    logic [31:0] glide_pos;
    sample_t     echo_line [NUM_CH][LINE_DEPTH];
    out_word_t   mixed_due [$];

    function automatic sample_t clip24(input longint v);
        sample_t r;
        if (v > SAMPLE_TOP)
            r = SAMPLE_TOP[SAMPLE_W-1:0];
        else if (v < SAMPLE_BOTTOM)
            r = SAMPLE_BOTTOM[SAMPLE_W-1:0];
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    // Moves the smoothed delay, runs both channels through their lines and
    // queues the mixed word this frame must produce.
    task automatic run_echo_frame(input in_word_t w);
        longint      gap_left;
        longint      glide_step;
        longint      next_pos;
        longint      x;
        longint      tap;
        longint      y;
        longint      r;
        logic [15:0] tap_idx;
        sample_t     dry [NUM_CH];
        sample_t     wet [NUM_CH];
        out_word_t   res;
        gap_left = regs.target_delay;
        gap_left = (gap_left <<< 16) - glide_pos;
        glide_step = regs.glide_coeff;
        glide_step = (glide_step * gap_left) >>> 16;
        next_pos = glide_pos;
        next_pos = next_pos + glide_step;
        if (next_pos < 0)
            next_pos = 0;
        else if (next_pos > GLIDE_TOP)
            next_pos = GLIDE_TOP;
        glide_pos = next_pos[31:0];

        // The 16-bit subtraction wraps exactly like the circular line.
        tap_idx = wr_ptr - 16'd1 - glide_pos[31:16];
        dry[0] = w.in_left;
        dry[1] = w.in_right;
        for (int c = 0; c < NUM_CH; c++)
        begin
            x   = dry[c];
            tap = echo_line[c][tap_idx];
            y   = regs.feedback_gain;
            y   = clip24(x + ((y * tap) >>> 16));
            r   = regs.mix_gain;
            r   = clip24(x + ((r * (y - x)) >>> 16));
            echo_line[c][wr_ptr] = y[SAMPLE_W-1:0];
            wet[c] = r[SAMPLE_W-1:0];
        end
        res.out_left  = wet[0];
        res.out_right = wet[1];
        mixed_due.push_back(res);
        wr_ptr = wr_ptr + 16'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
                for (int a = 0; a < LINE_DEPTH; a++)
                    echo_line[c][a] = '0;
            regs       = CFG_RESET;
            wr_ptr     = '0;
            glide_pos  = '0;
            mismatches = 0;
            frames_out = 0;
            mixed_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIX_GAIN:      regs.mix_gain      = cfg_data;
                    REG_TARGET_DELAY:  regs.target_delay  = cfg_data[15:0];
                    REG_FEEDBACK_GAIN: regs.feedback_gain = cfg_data[15:0];
                    REG_GLIDE_COEFF:   regs.glide_coeff   = cfg_data;
                    default:           ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (mixed_due.size() == 0)
                begin
                    $display("%0t: output word %h arrived with no frame waiting",
                             $time, out_word);
                    mismatches++;
                end
                else
                begin
                    want = mixed_due.pop_front();
                    frames_out++;
                    if (out_word.out_left !== want.out_left)
                    begin
                        $display("%0t: out_left expected %0d, got %0d",
                                 $time, want.out_left, out_word.out_left);
                        mismatches++;
                    end
                    if (out_word.out_right !== want.out_right)
                    begin
                        $display("%0t: out_right expected %0d, got %0d",
                                 $time, want.out_right, out_word.out_right);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
                run_echo_frame(in_word);
        end
    end

endmodule

// File: tb/sv/tb_smoothed_feedback_echo_top.sv
`timescale 1ns / 100ps

module tb_smoothed_feedback_echo_top;
    import sfe_pkg::*;

    localparam int FRAME_TARGET = 1400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT   = 4000;

    localparam sample_t S_MAX   = 24'sh7FFFFF;
    localparam sample_t S_MIN   = 24'sh800000;
    localparam sample_t S_NEG1  = 24'shFFFFFF;
    localparam sample_t S_ALT_A = 24'sh555555;
    localparam sample_t S_ALT_B = 24'shAAAAAA;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int frames_out;
    int frames_in   = 0;
    int idle_cycles = 0;
    int stall_pct   = 25;
    bit hold_out    = 1'b0;
    bit offering    = 1'b0;

    smoothed_feedback_echo_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smoothed_feedback_echo_checker echo_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .frames_out (frames_out)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Any word moving on any channel proves the block is still alive.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_smoothed_feedback_echo_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : receiver
        int pick;
        int span;
        bit hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_out)
            begin
                hold     = 1'b1;
                span     = HOLD_CYCLES;
                hold_out = 1'b0;
            end
            else if (stall_pct == 0)
            begin
                hold = 1'b0;
                span = $urandom_range(1, 8);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                hold = pick < stall_pct;
                span = (hold && pick < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            out_stall <= hold;
            repeat (span) @(posedge clk);
        end
    end

    function automatic sample_t rand_sample();
        sample_t s;
        case ($urandom_range(0, 19))
            0:       s = S_MAX;
            1:       s = S_MIN;
            2:       s = '0;
            3, 4, 5: s = sample_t'(int'($urandom_range(0, 4000)) - 2000);
            default: s = sample_t'($urandom);
        endcase
        return s;
    endfunction

    function automatic int pick_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        return gap;
    endfunction

    // Short delays dominate so that taps land on frames already written.
    function automatic logic [CFG_DATA_W-1:0] reg_value(input reg_idx_t r);
        logic [CFG_DATA_W-1:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        case (r)
            REG_MIX_GAIN:
            begin
                if (pick < 10)
                    v = '0;
                else if (pick < 20)
                    v = 17'd65536;
                else if (pick < 25)
                    v = '1;
                else
                    v = CFG_DATA_W'($urandom_range(0, 131071));
            end
            REG_TARGET_DELAY:
            begin
                if (pick < 8)
                    v = '0;
                else if (pick < 15)
                    v = 17'd65535;
                else if (pick < 30)
                    v = CFG_DATA_W'($urandom_range(0, 65535));
                else
                    v = CFG_DATA_W'($urandom_range(0, 48));
                v[16] = 1'($urandom_range(0, 1));
            end
            REG_FEEDBACK_GAIN:
            begin
                if (pick < 10)
                    v = '0;
                else if (pick < 20)
                    v = 17'd65535;
                else
                    v = CFG_DATA_W'($urandom_range(0, 65535));
                v[16] = 1'($urandom_range(0, 1));
            end
            default:
            begin
                if (pick < 10)
                    v = '0;
                else if (pick < 20)
                    v = 17'd65536;
                else if (pick < 25)
                    v = '1;
                else if (pick < 70)
                    v = CFG_DATA_W'($urandom_range(4096, 65536));
                else
                    v = CFG_DATA_W'($urandom_range(0, 4096));
            end
        endcase
        return v;
    endfunction

    task automatic drop_frame_valid();
        if (offering)
            in_valid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic send_frame(input sample_t left, input sample_t right, input int gap);
        if (gap > 0)
        begin
            drop_frame_valid();
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= in_word_t'{left, right};
        offering = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frames_in++;
    endtask

    // The caller lowers cfg_valid once its last write has gone through.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_unknown_reg();
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_GLIDE_COEFF) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
    endtask

    task automatic write_regs_random();
        for (int i = REG_MIX_GAIN; i <= REG_GLIDE_COEFF; i++)
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_IDX_W'(i), reg_value(reg_idx_t'(i)));
        if ($urandom_range(0, 7) == 0)
            write_unknown_reg();
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every frame sent has come back.
    task automatic settle();
        drop_frame_valid();
        wait (frames_out == frames_in);
    endtask

    initial
    begin : stimulus
        int n;
        bit gap_on;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset settings the delay is still gliding up from zero, so
        // every tap wraps around to the far, silent end of the lines.
        send_frame(S_MAX, S_MIN, 0);
        send_frame(S_MIN, S_MAX, 0);
        send_frame('0, S_NEG1, 0);
        send_frame(S_NEG1, '0, 0);
        send_frame(S_ALT_A, S_ALT_B, 0);
        send_frame(S_ALT_B, S_ALT_A, 0);
        settle();

        // Jump straight to a one-frame delay with full feedback and a wet gain
        // above unity. Bit 16 of the target write must be dropped.
        write_reg(REG_GLIDE_COEFF, 17'd65536);
        write_reg(REG_TARGET_DELAY, 17'h1_0001);
        write_reg(REG_FEEDBACK_GAIN, 17'd65535);
        write_reg(REG_MIX_GAIN, 17'h1_FFFF);
        cfg_valid <= 1'b0;
        for (int k = 0; k < 6; k++)
            send_frame(k < 3 ? S_MAX : S_MIN, k < 3 ? S_MIN : S_MAX, k % 2);
        settle();

        // A glide above unity toward the longest delay overshoots and clamps
        // at the top of the range. The unknown index must change nothing.
        write_unknown_reg();
        write_reg(REG_TARGET_DELAY, 17'd65535);
        write_reg(REG_GLIDE_COEFF, 17'h1_FFFF);
        write_reg(REG_MIX_GAIN, 17'd0);
        write_reg(REG_FEEDBACK_GAIN, 17'd0);
        cfg_valid <= 1'b0;
        for (int k = 0; k < 3; k++)
            send_frame(rand_sample(), rand_sample(), 0);
        settle();

        // Heading back to zero with the same coefficient undershoots below zero.
        write_reg(REG_TARGET_DELAY, 17'd0);
        write_reg(REG_MIX_GAIN, 17'd65536);
        write_reg(REG_FEEDBACK_GAIN, 17'd32768);
        cfg_valid <= 1'b0;
        for (int k = 0; k < 3; k++)
            send_frame(rand_sample(), rand_sample(), 0);

        for (int p = 0; frames_in < FRAME_TARGET; p++)
        begin
            settle();
            write_regs_random();
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
            gap_on = $urandom_range(0, 3) != 0;
            n = $urandom_range(40, 140);
            for (int k = 0; k < n; k++)
            begin
                // Once, the receiver holds off long enough for the block to
                // fill up and stall its input while frames keep coming.
                if (p == 1 && k == 0)
                    hold_out = 1'b1;
                if (k == n / 2 && $urandom_range(0, 3) == 0)
                    settle();
                send_frame(rand_sample(), rand_sample(), gap_on ? pick_gap() : 0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && frames_out == frames_in)
            $display("tb_smoothed_feedback_echo_top OK");
        else
            $display("tb_smoothed_feedback_echo_top NOT OK");
        $finish;
    end

endmodule
